### design/ufp_pkg.sv
package ufp_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hFF;

  localparam logic [1:0] POS_HUNT = 2'd0;
  localparam logic [1:0] POS_HIGH = 2'd1;
  localparam logic [1:0] POS_LOW  = 2'd2;
  localparam logic [1:0] POS_SUM  = 2'd3;

  localparam logic [2:0] ST_RESYNC = 3'd0;
  localparam logic [2:0] ST_HEADER = 3'd1;
  localparam logic [2:0] ST_BYTE   = 3'd2;
  localparam logic [2:0] ST_GOOD   = 3'd3;
  localparam logic [2:0] ST_CSUM   = 3'd4;
  localparam logic [2:0] ST_RANGE  = 3'd5;

  localparam logic REG_MIN_DISTANCE = 1'b0;
  localparam logic REG_MAX_DISTANCE = 1'b1;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] distance;
    logic        distance_valid;
    logic [31:0] sequence_count;
    logic [31:0] good_count;
    logic [31:0] range_error_count;
    logic [31:0] checksum_error_count;
    logic [31:0] resync_count;
  } ufp_result_t;

endpackage

### design/ultrasonic_frame_parser.sv
// Parses 4-byte distance frames (0xFF header, distance high, distance low,
// 8-bit checksum) from a serial byte stream, one byte per item, and returns
// one result item per byte with a status code, the held distance and the
// running counters as they stand after that byte. The frame state and
// counters update on the accepting edge and the result appears in the
// output register on the next cycle, so a new byte is accepted in every
// cycle as long as the output register is empty or being taken in that
// cycle. The distance bounds are written through the configuration port;
// the user must write them only while the block is idle (not enforced).
module ultrasonic_frame_parser import ufp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_distance,
  output logic        out_distance_valid,
  output logic [31:0] out_sequence_count,
  output logic [31:0] out_good_count,
  output logic [31:0] out_range_error_count,
  output logic [31:0] out_checksum_error_count,
  output logic [31:0] out_resync_count
);

  logic [15:0] min_dist_r;
  logic [15:0] max_dist_r;
  logic        out_valid_r;
  ufp_result_t res_r;
  ufp_result_t res_nxt;
  logic        accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= 16'd30;
      max_dist_r <= 16'd4500;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_DISTANCE: min_dist_r <= cfg_data;
        REG_MAX_DISTANCE: max_dist_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ufp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .rx_data      (in_rx_data),
    .min_distance (min_dist_r),
    .max_distance (max_dist_r),
    .result       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_status               = res_r.status;
  assign out_distance             = res_r.distance;
  assign out_distance_valid       = res_r.distance_valid;
  assign out_sequence_count       = res_r.sequence_count;
  assign out_good_count           = res_r.good_count;
  assign out_range_error_count    = res_r.range_error_count;
  assign out_checksum_error_count = res_r.checksum_error_count;
  assign out_resync_count         = res_r.resync_count;

endmodule

### design/ufp_core.sv
module ufp_core import ufp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  rx_data,
  input  logic [15:0] min_distance,
  input  logic [15:0] max_distance,
  output ufp_result_t result
);

  logic [1:0]  pos_r, pos_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic        valid_r, valid_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] range_r, range_nxt;
  logic [31:0] csum_r, csum_nxt;
  logic [31:0] resync_r, resync_nxt;
  logic [2:0]  status;
  logic [7:0]  calc_sum;
  logic [15:0] frame_dist;
  logic        in_range;

  assign calc_sum   = HDR_BYTE + high_r + low_r;
  assign frame_dist = {high_r, low_r};
  assign in_range   = (frame_dist >= min_distance) && (frame_dist <= max_distance);

  always_comb begin
    pos_nxt    = pos_r;
    high_nxt   = high_r;
    low_nxt    = low_r;
    dist_nxt   = dist_r;
    valid_nxt  = valid_r;
    seq_nxt    = seq_r;
    good_nxt   = good_r;
    range_nxt  = range_r;
    csum_nxt   = csum_r;
    resync_nxt = resync_r;
    status     = ST_RESYNC;
    case (pos_r)
      POS_HUNT: begin
        if (rx_data == HDR_BYTE) begin
          pos_nxt = POS_HIGH;
          status  = ST_HEADER;
        end else begin
          resync_nxt = resync_r + 32'd1;
          status     = ST_RESYNC;
        end
      end
      POS_HIGH: begin
        high_nxt = rx_data;
        pos_nxt  = POS_LOW;
        status   = ST_BYTE;
      end
      POS_LOW: begin
        low_nxt = rx_data;
        pos_nxt = POS_SUM;
        status  = ST_BYTE;
      end
      default: begin
        pos_nxt = POS_HUNT;
        if (calc_sum != rx_data) begin
          csum_nxt = csum_r + 32'd1;
          status   = ST_CSUM;
        end else if (in_range) begin
          dist_nxt  = frame_dist;
          valid_nxt = 1'b1;
          seq_nxt   = seq_r + 32'd1;
          good_nxt  = good_r + 32'd1;
          status    = ST_GOOD;
        end else begin
          range_nxt = range_r + 32'd1;
          status    = ST_RANGE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_HUNT;
      high_r   <= '0;
      low_r    <= '0;
      dist_r   <= '0;
      valid_r  <= 1'b0;
      seq_r    <= '0;
      good_r   <= '0;
      range_r  <= '0;
      csum_r   <= '0;
      resync_r <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      high_r   <= high_nxt;
      low_r    <= low_nxt;
      dist_r   <= dist_nxt;
      valid_r  <= valid_nxt;
      seq_r    <= seq_nxt;
      good_r   <= good_nxt;
      range_r  <= range_nxt;
      csum_r   <= csum_nxt;
      resync_r <= resync_nxt;
    end
  end

  always_comb begin
    result.status               = status;
    result.distance             = dist_nxt;
    result.distance_valid       = valid_nxt;
    result.sequence_count       = seq_nxt;
    result.good_count           = good_nxt;
    result.range_error_count    = range_nxt;
    result.checksum_error_count = csum_nxt;
    result.resync_count         = resync_nxt;
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import ufp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = REG_MIN_DISTANCE;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_distance;
  logic        out_distance_valid;
  logic [31:0] out_sequence_count;
  logic [31:0] out_good_count;
  logic [31:0] out_range_error_count;
  logic [31:0] out_checksum_error_count;
  logic [31:0] out_resync_count;

  ultrasonic_frame_parser dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_rx_data              (in_rx_data),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status              (out_status),
    .out_distance            (out_distance),
    .out_distance_valid      (out_distance_valid),
    .out_sequence_count      (out_sequence_count),
    .out_good_count          (out_good_count),
    .out_range_error_count   (out_range_error_count),
    .out_checksum_error_count(out_checksum_error_count),
    .out_resync_count        (out_resync_count)
  );

  always #2 clk = ~clk;

  int send_gap_pct = 19;
  int recv_stall_pct = 85;
  int items_sent = 0;
  int error_count = 0;

  logic [15:0] bound_lo = 16'd30;
  logic [15:0] bound_hi = 16'd4500;
  logic [1:0]  frame_pos = POS_HUNT;
  logic [7:0]  hi_byte = '0;
  logic [7:0]  lo_byte = '0;
  logic [15:0] held_mm = '0;
  logic        held_ok = 1'b0;
  logic [31:0] seq_cnt = '0;
  logic [31:0] good_cnt = '0;
  logic [31:0] range_cnt = '0;
  logic [31:0] csum_cnt = '0;
  logic [31:0] resync_cnt = '0;

  ufp_result_t results_due[$];
  ufp_result_t want;
  ufp_result_t got;

  function automatic ufp_result_t parser_result_for(input logic [7:0] rx);
    ufp_result_t r;
    logic [15:0] frame_mm;
    r.status = ST_BYTE;
    case (frame_pos)
      POS_HUNT: begin
        if (rx == HDR_BYTE) begin
          frame_pos = POS_HIGH;
          r.status = ST_HEADER;
        end else begin
          resync_cnt++;
          r.status = ST_RESYNC;
        end
      end
      POS_HIGH: begin
        hi_byte = rx;
        frame_pos = POS_LOW;
      end
      POS_LOW: begin
        lo_byte = rx;
        frame_pos = POS_SUM;
      end
      default: begin
        frame_pos = POS_HUNT;
        frame_mm = {hi_byte, lo_byte};
        if (rx != 8'(HDR_BYTE + hi_byte + lo_byte)) begin
          csum_cnt++;
          r.status = ST_CSUM;
        end else if (frame_mm >= bound_lo && frame_mm <= bound_hi) begin
          held_mm = frame_mm;
          held_ok = 1'b1;
          seq_cnt++;
          good_cnt++;
          r.status = ST_GOOD;
        end else begin
          range_cnt++;
          r.status = ST_RANGE;
        end
      end
    endcase
    r.distance = held_mm;
    r.distance_valid = held_ok;
    r.sequence_count = seq_cnt;
    r.good_count = good_cnt;
    r.range_error_count = range_cnt;
    r.checksum_error_count = csum_cnt;
    r.resync_count = resync_cnt;
    return r;
  endfunction

  function automatic void flag_error(input string what, input logic [31:0] exp_val,
                                     input logic [31:0] act_val);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s: expected %0h, got %0h", $realtime, what, exp_val, act_val);
    end
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got.status = out_status;
      got.distance = out_distance;
      got.distance_valid = out_distance_valid;
      got.sequence_count = out_sequence_count;
      got.good_count = out_good_count;
      got.range_error_count = out_range_error_count;
      got.checksum_error_count = out_checksum_error_count;
      got.resync_count = out_resync_count;
      if (results_due.size() == 0) begin
        flag_error("result item with nothing due, status", '0, 32'(got.status));
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status)
          flag_error("status", 32'(want.status), 32'(got.status));
        if (got.distance !== want.distance)
          flag_error("distance", 32'(want.distance), 32'(got.distance));
        if (got.distance_valid !== want.distance_valid)
          flag_error("distance_valid", 32'(want.distance_valid), 32'(got.distance_valid));
        if (got.sequence_count !== want.sequence_count)
          flag_error("sequence_count", want.sequence_count, got.sequence_count);
        if (got.good_count !== want.good_count)
          flag_error("good_count", want.good_count, got.good_count);
        if (got.range_error_count !== want.range_error_count)
          flag_error("range_error_count", want.range_error_count, got.range_error_count);
        if (got.checksum_error_count !== want.checksum_error_count)
          flag_error("checksum_error_count", want.checksum_error_count,
                     got.checksum_error_count);
        if (got.resync_count !== want.resync_count)
          flag_error("resync_count", want.resync_count, got.resync_count);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] rx);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_data <= rx;
    do begin
      @(posedge clk);
    end while (in_stall);
    results_due.push_back(parser_result_for(rx));
    items_sent++;
  endtask

  task automatic send_frame(input logic [15:0] frame_mm, input logic corrupt);
    logic [7:0] sum;
    sum = HDR_BYTE + frame_mm[15:8] + frame_mm[7:0];
    if (corrupt) begin
      sum ^= 8'($urandom_range(1, 255));
    end
    send_byte(HDR_BYTE);
    send_byte(frame_mm[15:8]);
    send_byte(frame_mm[7:0]);
    send_byte(sum);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(negedge clk);
  endtask

  task automatic write_bound(input logic idx, input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_MIN_DISTANCE) begin
      bound_lo = value;
    end else begin
      bound_hi = value;
    end
  endtask

  task automatic send_random_traffic(input int n_items);
    int stop_at;
    int kind;
    logic [15:0] frame_mm;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        case ($urandom_range(4))
          0: frame_mm = bound_lo;
          1: frame_mm = bound_hi;
          2: frame_mm = bound_lo - 16'd1;
          3: frame_mm = bound_hi + 16'd1;
          default: frame_mm = 16'($urandom_range(16'hFFFF));
        endcase
        send_frame(frame_mm, $urandom_range(99) < 15);
      end else if (kind < 85) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        send_byte(HDR_BYTE);
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_frame_directed();
    send_byte(8'h00);
    send_byte(8'hFE);
    send_frame(16'd30, 1'b0);
    send_frame(16'd29, 1'b0);
    send_frame(16'd4500, 1'b0);
    send_frame(16'h0000, 1'b0);
    send_frame(16'hFFFF, 1'b0);
    send_frame(16'h01FF, 1'b1);
  endtask

  task automatic test_wide_bounds();
    drain_results();
    write_bound(REG_MIN_DISTANCE, 16'd0);
    write_bound(REG_MAX_DISTANCE, 16'hFFFF);
    send_random_traffic(70);
    drain_results();
    send_random_traffic(70);
  endtask

  task automatic test_crossed_bounds();
    drain_results();
    write_bound(REG_MIN_DISTANCE, 16'd5000);
    write_bound(REG_MAX_DISTANCE, 16'd100);
    send_random_traffic(70);
    drain_results();
    write_bound(REG_MIN_DISTANCE, 16'd777);
    write_bound(REG_MAX_DISTANCE, 16'd777);
    send_random_traffic(70);
  endtask

  task automatic test_random_bounds();
    logic [15:0] a;
    logic [15:0] b;
    repeat (4) begin
      drain_results();
      a = 16'($urandom_range(16'hFFFF));
      b = 16'($urandom_range(16'hFFFF));
      write_bound(REG_MIN_DISTANCE, (a < b) ? a : b);
      write_bound(REG_MAX_DISTANCE, (a < b) ? b : a);
      send_random_traffic(30);
    end
    drain_results();
    write_bound(REG_MIN_DISTANCE, 16'hFFFF);
    write_bound(REG_MAX_DISTANCE, 16'hFFFF);
    send_random_traffic(20);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_frame_directed();
    test_wide_bounds();
    send_gap_pct = 85;
    recv_stall_pct = 19;
    test_crossed_bounds();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random_bounds();
    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
design/ufp_pkg.sv
design/ufp_core.sv
design/ultrasonic_frame_parser.sv
verif/tb.sv
